// File: hdl/tdfc_pkg.sv
// Shared types, constants and register codes for the depth to false color pipeline.
`default_nettype none

package tdfc_pkg;

  // Field widths.
  localparam int unsigned PhaseW   = 16;
  localparam int unsigned AmpW     = 16;
  localparam int unsigned DistW    = 15;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned OffW     = 14;
  localparam int unsigned ColorW   = 15;
  localparam int unsigned RangeW   = 14;
  localparam int unsigned ProdW    = PhaseW + RangeW;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Divider: dividend is 255 * numerator, quotient is one color channel.
  localparam int unsigned QuotW    = ChanW;
  localparam int unsigned DivNumW  = ColorW + ChanW;

  // Default phase word that corresponds to the full unambiguous range.
  localparam int unsigned PhaseFullScaleDef = 30000;

  localparam logic [PhaseW-1:0] CodeAdcOverflow = 16'd65500;
  localparam logic [PhaseW-1:0] CodeSaturation  = 16'd65400;
  localparam logic [RangeW-1:0] Range12Mm       = 14'd12500;
  localparam logic [RangeW-1:0] Range24Mm       = 14'd6250;
  localparam logic [ChanW-1:0]  ChanFull        = 8'd255;
  localparam logic [ChanW-1:0]  ChanOff         = 8'd0;

  // Reset values of the configuration registers.
  localparam logic [PhaseW-1:0] PhaseThrRst = 16'd200;
  localparam logic [AmpW-1:0]   AmpThrRst   = 16'd20;
  localparam logic [ColorW-1:0] ColorMaxRst = 15'd15000;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODULATION = 3'd0,
    CFG_OFFSET     = 3'd1,
    CFG_PHASE_THR  = 3'd2,
    CFG_AMP_THR    = 3'd3,
    CFG_COLOR_MIN  = 3'd4,
    CFG_COLOR_MAX  = 3'd5
  } cfg_idx_e;

  // Which color rule applies to a pixel; the band members name the fixed
  // full-scale channel first and the scaled channel second.
  typedef enum logic [2:0] {
    SEL_BLACK      = 3'd0,
    SEL_RED        = 3'd1,
    SEL_MAGENTA    = 3'd2,
    SEL_BLUE_RED   = 3'd3,
    SEL_BLUE_GREEN = 3'd4,
    SEL_GREEN_BLUE = 3'd5,
    SEL_GREEN_RED  = 3'd6,
    SEL_RED_GREEN  = 3'd7
  } color_sel_e;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [AmpW-1:0]   amplitude;
  } pixel_in_t;

  typedef struct packed {
    logic [DistW-1:0] distance_mm;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_out_t;

  typedef struct packed {
    logic              modulation_24mhz;
    logic [OffW-1:0]   offset_mm;
    logic [PhaseW-1:0] phase_threshold;
    logic [AmpW-1:0]   amp_min;
    logic [ColorW-1:0] color_min;
    logic [ColorW-1:0] color_max;
  } cfg_t;

  // Request into the divider: quotient = floor(dividend / span).
  typedef struct packed {
    logic [DistW-1:0]   distance_mm;
    color_sel_e         sel;
    logic [ColorW-1:0]  span;
    logic [DivNumW-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic [DistW-1:0] distance_mm;
    color_sel_e       sel;
    logic [QuotW-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: hdl/tdfc_dist.sv
// Phase to distance pipeline: validity checks, range scaling, full-scale division and offset.
`default_nettype none

module tdfc_dist
  import tdfc_pkg::*;
#(
  parameter int unsigned PhaseFullScale = PhaseFullScaleDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             valid_i,
  output logic             ready_o,
  input  pixel_in_t        pixel_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [DistW-1:0] dist_o
);

  localparam int unsigned NumStages  = 6;
  // Reciprocal of the full scale, scaled by 2^RecipShift.
  localparam int unsigned RecipShift = 32;
  localparam int unsigned RecipW     = RecipShift + 1;
  localparam int unsigned RecipLoW   = 16;
  localparam int unsigned RecipHiW   = RecipW - RecipLoW;
  localparam int unsigned PpLoW      = ProdW + RecipLoW;
  localparam int unsigned PpHiW      = ProdW + RecipHiW;
  localparam int unsigned SumW       = RecipShift + ProdW + 2;
  localparam int unsigned QpW        = ProdW + PhaseW;
  // The remainder stays below twice the divisor.
  localparam int unsigned ResW       = PhaseW + 2;

  localparam logic [RecipW-1:0]   Recip   =
      RecipW'((64'd1 << RecipShift) / 64'(PhaseFullScale));
  localparam logic [RecipLoW-1:0] RecipLo = Recip[RecipLoW-1:0];
  localparam logic [RecipHiW-1:0] RecipHi = Recip[RecipW-1:RecipLoW];
  localparam logic [PhaseW-1:0]   Divisor = PhaseW'(PhaseFullScale);

  // Stage handshake: a stage loads when it is empty or its successor moves.
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] vld_in;
  logic [NumStages:0]   rdy;
  logic [NumStages-1:0] ld;

  assign vld_in          = {vld_q[NumStages-2:0], valid_i};
  assign rdy[NumStages]  = ready_i;
  for (genvar k = 0; k < NumStages; k++) begin : g_ctrl
    assign rdy[k] = ~vld_q[k] | rdy[k+1];
    assign ld[k]  = rdy[k] & vld_in[k];
  end
  assign ready_o = rdy[0];
  assign valid_o = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  // Stage 0: invalid pixel detection and range times phase.
  logic             inv0_d, inv0_q;
  logic [RangeW-1:0] rng;
  logic [ProdW-1:0] x0_d, x0_q;

  assign rng    = cfg_i.modulation_24mhz ? Range24Mm : Range12Mm;
  assign inv0_d = (pixel_i.phase == CodeAdcOverflow) || (pixel_i.phase == CodeSaturation) ||
                  (pixel_i.phase < cfg_i.phase_threshold) ||
                  (pixel_i.amplitude < cfg_i.amp_min);
  assign x0_d   = ProdW'(rng) * ProdW'(pixel_i.phase);

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      inv0_q <= inv0_d;
      x0_q   <= x0_d;
    end
  end

  // Stage 1: product with the reciprocal, split into two partial products.
  logic             inv1_q;
  logic [ProdW-1:0] x1_q;
  logic [PpLoW-1:0] pp_lo_d, pp_lo_q;
  logic [PpHiW-1:0] pp_hi_d, pp_hi_q;

  assign pp_lo_d = PpLoW'(x0_q) * PpLoW'(RecipLo);
  assign pp_hi_d = PpHiW'(x0_q) * PpHiW'(RecipHi);

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      inv1_q  <= inv0_q;
      x1_q    <= x0_q;
      pp_lo_q <= pp_lo_d;
      pp_hi_q <= pp_hi_d;
    end
  end

  // Stage 2: combine the partial products into the estimated quotient.
  logic             inv2_q;
  logic [ResW-1:0]  x2_q;
  logic [SumW-1:0]  pp_sum;
  logic [ProdW-1:0] q0_d, q0_q;

  assign pp_sum = (SumW'(pp_hi_q) << RecipLoW) + SumW'(pp_lo_q);
  assign q0_d   = pp_sum[RecipShift +: ProdW];

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      inv2_q <= inv1_q;
      x2_q   <= x1_q[ResW-1:0];
      q0_q   <= q0_d;
    end
  end

  // Stage 3: back-multiply the estimate; only the low bits matter.
  logic             inv3_q;
  logic [ResW-1:0]  x3_q;
  logic [ProdW-1:0] q0_3_q;
  logic [QpW-1:0]   qp_full;
  logic [ResW-1:0]  qp_q;

  assign qp_full = QpW'(q0_q) * QpW'(Divisor);

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      inv3_q <= inv2_q;
      x3_q   <= x2_q;
      q0_3_q <= q0_q;
      qp_q   <= qp_full[ResW-1:0];
    end
  end

  // Stage 4: the estimate is low by at most one; fix it from the remainder.
  logic             inv4_q;
  logic [ResW-1:0]  rem;
  logic             fix;
  logic [ProdW-1:0] q_d, q_q;

  assign rem = x3_q - qp_q;
  assign fix = rem >= ResW'(Divisor);
  assign q_d = q0_3_q + ProdW'(fix);

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      inv4_q <= inv3_q;
      q_q    <= q_d;
    end
  end

  // Stage 5: subtract the offset, floor at zero and saturate.
  logic [ProdW-1:0] diff;
  logic [DistW-1:0] dist_d, dist_q;

  assign diff = q_q - ProdW'(cfg_i.offset_mm);
  always_comb begin
    if (inv4_q || (q_q <= ProdW'(cfg_i.offset_mm))) begin
      dist_d = '0;
    end else if (|diff[ProdW-1:DistW]) begin
      dist_d = '1;
    end else begin
      dist_d = diff[DistW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      dist_q <= dist_d;
    end
  end

  assign dist_o = dist_q;

endmodule

`default_nettype wire

// File: hdl/tdfc_band.sv
// Color band selection: picks the color rule and the numerator for the channel scaling.
`default_nettype none

module tdfc_band
  import tdfc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [DistW-1:0] dist_i,
  output logic             valid_o,
  input  logic             ready_i,
  output div_req_t         req_o
);

  localparam int unsigned NumStages = 3;
  localparam int unsigned N5W       = ColorW + 3;

  // Stage handshake.
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] vld_in;
  logic [NumStages:0]   rdy;
  logic [NumStages-1:0] ld;

  assign vld_in         = {vld_q[NumStages-2:0], valid_i};
  assign rdy[NumStages] = ready_i;
  for (genvar k = 0; k < NumStages; k++) begin : g_ctrl
    assign rdy[k] = ~vld_q[k] | rdy[k+1];
    assign ld[k]  = rdy[k] & vld_in[k];
  end
  assign ready_o = rdy[0];
  assign valid_o = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  // Stage 0: range compares, span and position inside the span.
  logic              zero_q, below_q, above_q;
  logic [DistW-1:0]  d0_q;
  logic [ColorW-1:0] span0_q, n0_q;

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      zero_q  <= (dist_i == '0);
      below_q <= (dist_i < cfg_i.color_min);
      above_q <= (dist_i > cfg_i.color_max);
      span0_q <= cfg_i.color_max - cfg_i.color_min;
      n0_q    <= dist_i - cfg_i.color_min;
      d0_q    <= dist_i;
    end
  end

  // Stage 1: band decision on 5n against multiples of the span.
  logic [N5W-1:0]    n5, s1x, s2x, s3x, s4x;
  color_sel_e        sel_d, sel1_q;
  logic [N5W-1:0]    num_w;
  logic [DistW-1:0]  d1_q;
  logic [ColorW-1:0] span1_q, num1_q;

  assign n5  = (N5W'(n0_q) << 2) + N5W'(n0_q);
  assign s1x = N5W'(span0_q);
  assign s2x = N5W'(span0_q) << 1;
  assign s3x = (N5W'(span0_q) << 1) + N5W'(span0_q);
  assign s4x = N5W'(span0_q) << 2;

  always_comb begin
    num_w = '0;
    if (zero_q) begin
      sel_d = SEL_BLACK;
    end else if (below_q) begin
      sel_d = SEL_RED;
    end else if (above_q) begin
      sel_d = SEL_MAGENTA;
    end else if (span0_q == '0) begin
      sel_d = SEL_BLACK;
    end else if (n5 > s4x) begin
      sel_d = SEL_BLUE_RED;
      num_w = n5 - s4x;
    end else if (n5 > s3x) begin
      sel_d = SEL_BLUE_GREEN;
      num_w = s4x - n5;
    end else if (n5 > s2x) begin
      sel_d = SEL_GREEN_BLUE;
      num_w = n5 - s2x;
    end else if (n5 > s1x) begin
      sel_d = SEL_GREEN_RED;
      num_w = s2x - n5;
    end else begin
      sel_d = SEL_RED_GREEN;
      num_w = n5;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      sel1_q  <= sel_d;
      num1_q  <= num_w[ColorW-1:0];
      span1_q <= span0_q;
      d1_q    <= d0_q;
    end
  end

  // Stage 2: dividend is 255 times the numerator.
  div_req_t req_q;

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      req_q.distance_mm <= d1_q;
      req_q.sel         <= sel1_q;
      req_q.span        <= span1_q;
      req_q.dividend    <= (DivNumW'(num1_q) << ChanW) - DivNumW'(num1_q);
    end
  end

  assign req_o = req_q;

endmodule

`default_nettype wire

// File: hdl/tdfc_div.sv
// Pipelined restoring divider: one quotient bit per stage, for the color channel scaling.
`default_nettype none

module tdfc_div
  import tdfc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  div_req_t req_i,
  output logic     valid_o,
  input  logic     ready_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned NumStages = QuotW;

  typedef struct packed {
    logic [DistW-1:0]   distance_mm;
    color_sel_e         sel;
    logic [ColorW-1:0]  span;
    logic [DivNumW-1:0] rem;
    logic [QuotW-1:0]   quot;
  } div_work_t;

  // Stage handshake.
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] vld_in;
  logic [NumStages:0]   rdy;
  logic [NumStages-1:0] ld;

  assign vld_in         = {vld_q[NumStages-2:0], valid_i};
  assign rdy[NumStages] = ready_i;
  for (genvar k = 0; k < NumStages; k++) begin : g_ctrl
    assign rdy[k] = ~vld_q[k] | rdy[k+1];
    assign ld[k]  = rdy[k] & vld_in[k];
  end
  assign ready_o = rdy[0];
  assign valid_o = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  div_work_t work_in [NumStages];
  div_work_t work_nx [NumStages];
  div_work_t work_q  [NumStages];

  // Each stage tries to subtract the span shifted to its quotient bit.
  for (genvar j = 0; j < NumStages; j++) begin : g_stage
    localparam int unsigned Bit = NumStages - 1 - j;

    logic [DivNumW:0] trial;

    if (j == 0) begin : g_head
      // The quotient is below 256 because the numerator never exceeds the span.
      assign work_in[j] = '{distance_mm: req_i.distance_mm, sel: req_i.sel,
                            span: req_i.span, rem: req_i.dividend, quot: '0};
    end else begin : g_link
      assign work_in[j] = work_q[j-1];
    end

    assign trial = {1'b0, work_in[j].rem} - ((DivNumW + 1)'(work_in[j].span) << Bit);

    always_comb begin
      work_nx[j] = work_in[j];
      if (!trial[DivNumW]) begin
        work_nx[j].rem       = trial[DivNumW-1:0];
        work_nx[j].quot[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ld[j]) begin
        work_q[j] <= work_nx[j];
      end
    end
  end

  assign rsp_o.distance_mm = work_q[NumStages-1].distance_mm;
  assign rsp_o.sel         = work_q[NumStages-1].sel;
  assign rsp_o.quotient    = work_q[NumStages-1].quot;

endmodule

`default_nettype wire

// File: hdl/tof_depth_to_false_color_core.sv
// Top level of the time-of-flight depth to false color pipeline.
//
// Takes one pixel (phase, amplitude) per clock while the input is ready and returns
// its distance in mm and a rainbow false color. The block is fully pipelined: a new
// item is accepted every cycle until output stalls have filled every stage, and each
// item passes through 6 stages for the distance multiply and reciprocal division, 3
// for band selection, 8 for the divider that produces one channel bit per stage, and
// 1 output register. Stalls on the output side fill empty stages first, so input
// stays ready until every stage holds an item. Configuration registers are written
// through a simple write port and are to be changed only while no item is in flight.
`default_nettype none

module tof_depth_to_false_color_core
  import tdfc_pkg::*;
#(
  parameter int unsigned PhaseFullScale = PhaseFullScaleDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pixel_in_t           in_pixel_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pixel_out_t          out_pixel_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers.
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.modulation_24mhz <= 1'b0;
      cfg_q.offset_mm        <= '0;
      cfg_q.phase_threshold  <= PhaseThrRst;
      cfg_q.amp_min          <= AmpThrRst;
      cfg_q.color_min        <= '0;
      cfg_q.color_max        <= ColorMaxRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODULATION: cfg_q.modulation_24mhz <= cfg_data_i[0];
        CFG_OFFSET:     cfg_q.offset_mm        <= cfg_data_i[OffW-1:0];
        CFG_PHASE_THR:  cfg_q.phase_threshold  <= cfg_data_i[PhaseW-1:0];
        CFG_AMP_THR:    cfg_q.amp_min          <= cfg_data_i[AmpW-1:0];
        CFG_COLOR_MIN:  cfg_q.color_min        <= cfg_data_i[ColorW-1:0];
        CFG_COLOR_MAX:  cfg_q.color_max        <= cfg_data_i[ColorW-1:0];
        default: ;
      endcase
    end
  end

  // Distance pipeline.
  logic             dist_valid, dist_ready;
  logic [DistW-1:0] dist_mm;

  tdfc_dist #(
    .PhaseFullScale(PhaseFullScale)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .valid_i(in_valid_i),
    .ready_o(in_ready_o),
    .pixel_i(in_pixel_i),
    .valid_o(dist_valid),
    .ready_i(dist_ready),
    .dist_o (dist_mm)
  );

  // Band selection.
  logic     req_valid, req_ready;
  div_req_t req;

  tdfc_band u_band (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .valid_i(dist_valid),
    .ready_o(dist_ready),
    .dist_i (dist_mm),
    .valid_o(req_valid),
    .ready_i(req_ready),
    .req_o  (req)
  );

  // Channel scaling divider.
  logic     rsp_valid, rsp_ready;
  div_rsp_t rsp;

  tdfc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(req_valid),
    .ready_o(req_ready),
    .req_i  (req),
    .valid_o(rsp_valid),
    .ready_i(rsp_ready),
    .rsp_o  (rsp)
  );

  // Color assembly from the selected rule and the scaled channel.
  pixel_out_t out_d, out_q;
  logic       out_vld_q;

  always_comb begin
    out_d.distance_mm = rsp.distance_mm;
    out_d.red         = ChanOff;
    out_d.green       = ChanOff;
    out_d.blue        = ChanOff;
    unique case (rsp.sel)
      SEL_BLACK: ;
      SEL_RED: begin
        out_d.red = ChanFull;
      end
      SEL_MAGENTA: begin
        out_d.red  = ChanFull;
        out_d.blue = ChanFull;
      end
      SEL_BLUE_RED: begin
        out_d.red  = rsp.quotient;
        out_d.blue = ChanFull;
      end
      SEL_BLUE_GREEN: begin
        out_d.green = rsp.quotient;
        out_d.blue  = ChanFull;
      end
      SEL_GREEN_BLUE: begin
        out_d.green = ChanFull;
        out_d.blue  = rsp.quotient;
      end
      SEL_GREEN_RED: begin
        out_d.red   = rsp.quotient;
        out_d.green = ChanFull;
      end
      SEL_RED_GREEN: begin
        out_d.red   = ChanFull;
        out_d.green = rsp.quotient;
      end
      default: ;
    endcase
  end

  // Output register.
  assign rsp_ready = ~out_vld_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (rsp_ready) begin
      out_vld_q <= rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_ready && rsp_valid) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_pixel_o = out_q;

  // Input back-pressure only when every stage is full and the output is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while the pipeline still has room");

  // An item with zero distance, such as an invalid pixel, always shows black.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_pixel_o.distance_mm == '0)) |->
      ((out_pixel_o.red == ChanOff) && (out_pixel_o.green == ChanOff) &&
       (out_pixel_o.blue == ChanOff)))
    else $error("zero distance item is not black");

  // Every color rule leaves at least one channel dark.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_pixel_o.red == ChanOff) || (out_pixel_o.green == ChanOff) ||
                     (out_pixel_o.blue == ChanOff)))
    else $error("color item has all three channels lit");

endmodule

`default_nettype wire
